@@ hw/rtl/plin_pkg.sv @@
// Package for the pressure-to-flow linearizer: widths, scaling constants,
// coefficient and root-cell payload types. No dependencies.
package plin_pkg;

    localparam int SCALE_FACTOR = 60;
    localparam int RAW_W        = 16;
    localparam int MAG_W        = 16;
    localparam int FRAC_IN      = 24;
    localparam int C_W          = 24;
    localparam int FLOW_W       = 17;
    localparam int CFG_IDX_W    = 2;
    localparam int HSHIFT       = 12;
    localparam int OSHIFT       = 8;
    localparam int FLOW_MAX     = 65535;
    localparam int FLOW_MIN     = -65536;

    // magnitude scaling: q = mag * QUO + floor(mag * REMD / SCALE_FACTOR)
    localparam longint unsigned QUO   = (64'd1 << FRAC_IN) / SCALE_FACTOR;
    localparam longint unsigned REMD  = (64'd1 << FRAC_IN) % SCALE_FACTOR;
    localparam int QUO_W  = $clog2(QUO + 1);
    localparam int RD_W   = $clog2(SCALE_FACTOR + 1);
    localparam int HI_W   = MAG_W + QUO_W;
    localparam int Y_W    = MAG_W + RD_W;
    localparam int RCP_N  = MAG_W + 2 * RD_W;
    localparam longint unsigned RCP_M =
        ((64'd1 << RCP_N) + SCALE_FACTOR - 1) / SCALE_FACTOR;
    localparam int M_W    = RCP_N + 1;
    localparam int R_W    = Y_W + M_W;

    // root width
    localparam longint unsigned Q_MAX = (64'd32768 << FRAC_IN) / SCALE_FACTOR;
    localparam int Q_BITS = $clog2(Q_MAX + 1);
    localparam int S_W    = (Q_BITS + 1) / 2;
    localparam int Q_W    = 2 * S_W;
    localparam int REM_W  = S_W + 2;

    // polynomial widths
    localparam int P1_W   = C_W + S_W + 1;
    localparam int A1_W   = C_W + S_W - 10;
    localparam int P2_W   = A1_W + S_W + 1;
    localparam int A2_W   = A1_W + S_W - 10;
    localparam int LO_W   = 20;
    localparam int HI2_W  = A2_W - LO_W;
    localparam int PH_W   = HI2_W + S_W + 1;
    localparam int PL_W   = LO_W + S_W;
    localparam int P3_W   = A2_W + S_W + 1;
    localparam int A3_W   = A2_W + S_W - 10;
    localparam int NEG_W  = A3_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUBIC,
        CFG_SQUARE,
        CFG_LINEAR,
        CFG_OFFSET
    } cfg_idx_t;

    typedef struct packed {
        logic signed [C_W-1:0] c3;
        logic signed [C_W-1:0] c2;
        logic signed [C_W-1:0] c1;
        logic signed [C_W-1:0] c0;
    } coef_t;

    localparam coef_t COEF_RST = '{
        c3: -24'sd439,
        c2: 24'sd17144,
        c1: 24'sd486873,
        c0: -24'sd61630
    };

    typedef struct packed {
        logic [Q_W-1:0]   q;
        logic [REM_W-1:0] rem;
        logic [S_W-1:0]   root;
        logic             neg;
    } sqrt_t;

endpackage

@@ hw/rtl/plin_if.sv @@
// Stream interfaces for samples and flow results.
// Depends on plin_pkg.
interface plin_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [plin_pkg::RAW_W-1:0] raw_pressure;

    modport source (output valid, output raw_pressure, input ready);
    modport sink   (input valid, input raw_pressure, output ready);
endinterface

interface plin_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [plin_pkg::FLOW_W-1:0] flow_value;
    logic                               saturated;

    modport source (output valid, output flow_value, output saturated, input ready);
    modport sink   (input valid, input flow_value, input saturated, output ready);
endinterface

@@ hw/rtl/plin_front.sv @@
// Front end: magnitude and scaling by 2^24/SCALE_FACTOR, three stages.
// Depends on plin_pkg and plin_if.
module plin_front (
    input  logic            clk,
    input  logic            rst_n,
    plin_in_if.sink         sample,
    output logic            out_valid,
    input  logic            out_ready,
    output plin_pkg::sqrt_t out_data
);

    logic [2:0]                   v_reg;
    logic [2:0]                   en;
    logic [plin_pkg::RAW_W-1:0]   raw;
    logic                         neg;
    logic [plin_pkg::MAG_W-1:0]   mag;
    logic [plin_pkg::HI_W-1:0]    hi0_next;
    logic [plin_pkg::Y_W-1:0]     y0_next;
    logic [plin_pkg::R_W-1:0]     r1_next;
    logic [plin_pkg::Q_W-1:0]     q2_next;
    logic [plin_pkg::HI_W-1:0]    hi0_reg;
    logic [plin_pkg::HI_W-1:0]    hi1_reg;
    logic [plin_pkg::Y_W-1:0]     y0_reg;
    logic [plin_pkg::R_W-1:0]     r1_reg;
    logic [plin_pkg::Q_W-1:0]     q2_reg;
    logic [2:0]                   neg_reg;

    always_comb
    begin
        en[2] = !v_reg[2] || out_ready;
        en[1] = !v_reg[1] || en[2];
        en[0] = !v_reg[0] || en[1];
    end

    assign sample.ready = en[0];

    always_comb
    begin
        raw      = sample.raw_pressure;
        neg      = raw[plin_pkg::RAW_W-1];
        mag      = neg ? (~raw + 1'b1) : raw;
        hi0_next = plin_pkg::HI_W'(mag) * plin_pkg::HI_W'(plin_pkg::QUO);
        y0_next  = plin_pkg::Y_W'(mag) * plin_pkg::Y_W'(plin_pkg::REMD);
        r1_next  = plin_pkg::R_W'(y0_reg) * plin_pkg::R_W'(plin_pkg::RCP_M);
        q2_next  = plin_pkg::Q_W'(hi1_reg + plin_pkg::HI_W'(r1_reg >> plin_pkg::RCP_N));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= sample.valid;
            end
            if (en[1])
            begin
                v_reg[1] <= v_reg[0];
            end
            if (en[2])
            begin
                v_reg[2] <= v_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            hi0_reg    <= hi0_next;
            y0_reg     <= y0_next;
            neg_reg[0] <= neg;
        end
        if (en[1])
        begin
            hi1_reg    <= hi0_reg;
            r1_reg     <= r1_next;
            neg_reg[1] <= neg_reg[0];
        end
        if (en[2])
        begin
            q2_reg     <= q2_next;
            neg_reg[2] <= neg_reg[1];
        end
    end

    assign out_valid     = v_reg[2];
    assign out_data.q    = q2_reg;
    assign out_data.rem  = '0;
    assign out_data.root = '0;
    assign out_data.neg  = neg_reg[2];

endmodule

@@ hw/rtl/plin_sqrt_cell.sv @@
// One cell of the square-root chain: resolves one root bit per cell.
// Depends on plin_pkg.
module plin_sqrt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  plin_pkg::sqrt_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output plin_pkg::sqrt_t out_data
);

    logic                         valid_reg;
    plin_pkg::sqrt_t              data_reg;
    plin_pkg::sqrt_t              data_next;
    logic [plin_pkg::REM_W-1:0]   rem_sh;
    logic [plin_pkg::REM_W-1:0]   trial;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        rem_sh      = {in_data.rem[plin_pkg::REM_W-3:0],
                       in_data.q[plin_pkg::Q_W-1:plin_pkg::Q_W-2]};
        trial       = {in_data.root, 2'b01};
        data_next.q = {in_data.q[plin_pkg::Q_W-3:0], 2'b00};
        data_next.neg = in_data.neg;
        if (rem_sh >= trial)
        begin
            data_next.rem  = rem_sh - trial;
            data_next.root = {in_data.root[plin_pkg::S_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem  = rem_sh;
            data_next.root = {in_data.root[plin_pkg::S_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hw/rtl/plin_horner.sv @@
// Cubic by Horner's rule on the root, sign, floor from Q.8 to integer and saturation.
// Eight stages; depends on plin_pkg and plin_if.
module plin_horner (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  plin_pkg::sqrt_t in_data,
    input  plin_pkg::coef_t coef,
    plin_out_if.source      result
);

    localparam int NST = 8;

    logic [NST-1:0]                      v_reg;
    logic [NST-1:0]                      en;
    logic [NST-2:0]                      neg_reg;
    logic [plin_pkg::S_W-1:0]            s_reg [4];
    logic signed [plin_pkg::S_W:0]       s_in;
    logic signed [plin_pkg::S_W:0]       s1;
    logic signed [plin_pkg::S_W:0]       s3;
    logic signed [plin_pkg::P1_W-1:0]    p1_reg;
    logic signed [plin_pkg::A1_W-1:0]    a1_reg;
    logic signed [plin_pkg::P2_W-1:0]    p2_reg;
    logic signed [plin_pkg::A2_W-1:0]    a2_reg;
    logic signed [plin_pkg::PH_W-1:0]    ph_reg;
    logic [plin_pkg::PL_W-1:0]           pl_reg;
    logic signed [plin_pkg::P3_W-1:0]    p3_reg;
    logic signed [plin_pkg::A3_W-1:0]    a3_reg;
    logic signed [plin_pkg::HI2_W-1:0]   a2_hi;
    logic [plin_pkg::LO_W-1:0]           a2_lo;
    logic signed [plin_pkg::NEG_W-1:0]   nv;
    logic signed [plin_pkg::NEG_W-1:0]   fl;
    logic signed [plin_pkg::FLOW_W-1:0]  flow_next;
    logic                                sat_next;
    logic signed [plin_pkg::FLOW_W-1:0]  flow_reg;
    logic                                sat_reg;

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || result.ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    always_comb
    begin
        s_in  = $signed({1'b0, in_data.root});
        s1    = $signed({1'b0, s_reg[1]});
        s3    = $signed({1'b0, s_reg[3]});
        a2_hi = a2_reg[plin_pkg::A2_W-1:plin_pkg::LO_W];
        a2_lo = a2_reg[plin_pkg::LO_W-1:0];
        nv    = neg_reg[6] ? -plin_pkg::NEG_W'(a3_reg) : plin_pkg::NEG_W'(a3_reg);
        fl    = nv >>> plin_pkg::OSHIFT;
        if (fl > plin_pkg::NEG_W'(plin_pkg::FLOW_MAX))
        begin
            flow_next = plin_pkg::FLOW_W'(plin_pkg::FLOW_MAX);
            sat_next  = 1'b1;
        end
        else if (fl < plin_pkg::NEG_W'(plin_pkg::FLOW_MIN))
        begin
            flow_next = plin_pkg::FLOW_W'(plin_pkg::FLOW_MIN);
            sat_next  = 1'b1;
        end
        else
        begin
            flow_next = fl[plin_pkg::FLOW_W-1:0];
            sat_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p1_reg     <= coef.c3 * s_in;
            s_reg[0]   <= in_data.root;
            neg_reg[0] <= in_data.neg;
        end
        if (en[1])
        begin
            a1_reg     <= plin_pkg::A1_W'(p1_reg >>> plin_pkg::HSHIFT)
                          + plin_pkg::A1_W'(coef.c2);
            s_reg[1]   <= s_reg[0];
            neg_reg[1] <= neg_reg[0];
        end
        if (en[2])
        begin
            p2_reg     <= a1_reg * s1;
            s_reg[2]   <= s_reg[1];
            neg_reg[2] <= neg_reg[1];
        end
        if (en[3])
        begin
            a2_reg     <= plin_pkg::A2_W'(p2_reg >>> plin_pkg::HSHIFT)
                          + plin_pkg::A2_W'(coef.c1);
            s_reg[3]   <= s_reg[2];
            neg_reg[3] <= neg_reg[2];
        end
        if (en[4])
        begin
            ph_reg     <= a2_hi * s3;
            pl_reg     <= plin_pkg::PL_W'(a2_lo) * plin_pkg::PL_W'(s_reg[3]);
            neg_reg[4] <= neg_reg[3];
        end
        if (en[5])
        begin
            p3_reg     <= (plin_pkg::P3_W'(ph_reg) <<< plin_pkg::LO_W)
                          + $signed(plin_pkg::P3_W'(pl_reg));
            neg_reg[5] <= neg_reg[4];
        end
        if (en[6])
        begin
            a3_reg     <= plin_pkg::A3_W'(p3_reg >>> plin_pkg::HSHIFT)
                          + plin_pkg::A3_W'(coef.c0);
            neg_reg[6] <= neg_reg[5];
        end
        if (en[7])
        begin
            flow_reg   <= flow_next;
            sat_reg    <= sat_next;
        end
    end

    assign result.valid      = v_reg[NST-1];
    assign result.flow_value = flow_reg;
    assign result.saturated  = sat_reg;

endmodule

@@ hw/rtl/pressure_to_flow_linearizer_core.sv @@
// Pressure-to-flow linearizer top level.
// Pipeline: 3 scaling stages, one root cell per root bit, 8 polynomial
// stages, from sample transfer to result. Throughput: one sample per cycle
// while not stalled; each stage holds its item only while the next is full.
// Reset clears all stage valids and loads the default coefficients.
// Depends on plin_pkg, plin_if, plin_front, plin_sqrt_cell, plin_horner.
module pressure_to_flow_linearizer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    plin_in_if.sink                       sample,
    plin_out_if.source                    result,
    input  logic                          cfg_wr_en,
    input  logic [plin_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [plin_pkg::C_W-1:0]      cfg_wdata
);

    plin_pkg::coef_t  coef_reg;
    logic             chain_valid [plin_pkg::S_W+1];
    logic             chain_ready [plin_pkg::S_W+1];
    plin_pkg::sqrt_t  chain_data  [plin_pkg::S_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= plin_pkg::COEF_RST;
        end
        else if (cfg_wr_en)
        begin
            case (plin_pkg::cfg_idx_t'(cfg_index))
                plin_pkg::CFG_CUBIC:  coef_reg.c3 <= cfg_wdata;
                plin_pkg::CFG_SQUARE: coef_reg.c2 <= cfg_wdata;
                plin_pkg::CFG_LINEAR: coef_reg.c1 <= cfg_wdata;
                plin_pkg::CFG_OFFSET: coef_reg.c0 <= cfg_wdata;
                default: ;
            endcase
        end
    end

    plin_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar i = 0; i < plin_pkg::S_W; i++)
    begin : g_root
        plin_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    plin_horner u_horner (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chain_valid[plin_pkg::S_W]),
        .in_ready (chain_ready[plin_pkg::S_W]),
        .in_data  (chain_data[plin_pkg::S_W]),
        .coef     (coef_reg),
        .result   (result)
    );

    a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated |->
            result.flow_value == plin_pkg::FLOW_W'(plin_pkg::FLOW_MAX) ||
            result.flow_value == plin_pkg::FLOW_W'(plin_pkg::FLOW_MIN))
        else $error("saturated result not at a bound");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> result.valid && !result.ready)
        else $error("input stalled while output free");

    a_cfg_offset: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en && cfg_index == plin_pkg::CFG_OFFSET |=>
            coef_reg.c0 == $past(cfg_wdata))
        else $error("offset coefficient not updated");

endmodule

@@ sim/plin_flow_checker.sv @@
`timescale 1ns / 100ps
// Checker for the pressure-to-flow linearizer: predicts each flow result
// from accepted samples and coefficient writes, compares at the output.
// Depends on plin_pkg and plin_if.
module plin_flow_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    plin_in_if                             smp,
    plin_out_if                            res,
    input  logic                           cfg_wr_en,
    input  logic [plin_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [plin_pkg::C_W-1:0]       cfg_wdata,
    output int                             errors,
    output int                             pending
);

    typedef struct {
        logic signed [plin_pkg::FLOW_W-1:0] flow;
        logic                               sat;
    } flow_t;

    flow_t  flow_q[$];
    longint c3, c2, c1, c0;

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic flow_t linearize(logic signed [plin_pkg::RAW_W-1:0] raw);
        flow_t           f;
        longint          mag;
        longint          s;
        longint          acc;
        longint          fl;
        longint unsigned q;
        mag = raw;
        if (mag < 0)
            mag = -mag;
        q = (longint'(mag) << plin_pkg::FRAC_IN) / plin_pkg::SCALE_FACTOR;
        s = longint'(int_root(q));
        acc = c3;
        acc = ((acc * s) >>> plin_pkg::HSHIFT) + c2;
        acc = ((acc * s) >>> plin_pkg::HSHIFT) + c1;
        acc = ((acc * s) >>> plin_pkg::HSHIFT) + c0;
        if (raw < 0)
            acc = -acc;
        fl = acc >>> plin_pkg::OSHIFT;
        f.sat = 1'b0;
        if (fl > plin_pkg::FLOW_MAX)
        begin
            fl = plin_pkg::FLOW_MAX;
            f.sat = 1'b1;
        end
        else if (fl < plin_pkg::FLOW_MIN)
        begin
            fl = plin_pkg::FLOW_MIN;
            f.sat = 1'b1;
        end
        f.flow = fl[plin_pkg::FLOW_W-1:0];
        return f;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        flow_t e;
        if (!rst_n)
        begin
            c3 = longint'(plin_pkg::COEF_RST.c3);
            c2 = longint'(plin_pkg::COEF_RST.c2);
            c1 = longint'(plin_pkg::COEF_RST.c1);
            c0 = longint'(plin_pkg::COEF_RST.c0);
            flow_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    plin_pkg::CFG_CUBIC:  c3 = longint'($signed(cfg_wdata));
                    plin_pkg::CFG_SQUARE: c2 = longint'($signed(cfg_wdata));
                    plin_pkg::CFG_LINEAR: c1 = longint'($signed(cfg_wdata));
                    plin_pkg::CFG_OFFSET: c0 = longint'($signed(cfg_wdata));
                    default: ;
                endcase
            end
            if (res.valid && res.ready)
            begin
                if (flow_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transfer flow=%0d sat=%0b",
                             $time, res.flow_value, res.saturated);
                end
                else
                begin
                    e = flow_q.pop_front();
                    if (res.flow_value !== e.flow || res.saturated !== e.sat)
                    begin
                        errors++;
                        $display("%0t: mismatch expected flow=%0d sat=%0b, %s",
                                 $time, e.flow, e.sat,
                                 $sformatf("actual flow=%0d sat=%0b",
                                           res.flow_value, res.saturated));
                    end
                end
            end
            if (smp.valid && smp.ready)
                flow_q.push_back(linearize(smp.raw_pressure));
            pending = flow_q.size();
        end
    end
endmodule

@@ sim/tb_pressure_to_flow_linearizer_core.sv @@
`timescale 1ns / 100ps
// Testbench top for pressure_to_flow_linearizer_core: drives samples and
// coefficient writes, stalls the output, and reports the verdict.
// Depends on plin_pkg, plin_if, plin_flow_checker and the core.
module tb_pressure_to_flow_linearizer_core;

    localparam int LIMIT = 400000;
    localparam int DRAIN = 40;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [plin_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [plin_pkg::C_W-1:0]       cfg_wdata = '0;
    int                             errors;
    int                             pending;
    int                             cycles = 0;
    bit                             idle_on = 1'b1;
    bit                             hold_req = 1'b0;

    plin_in_if  smp();
    plin_out_if res();

    initial
    begin
        smp.valid = 1'b0;
        smp.raw_pressure = '0;
        res.ready = 1'b0;
    end

    pressure_to_flow_linearizer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (smp),
        .result    (res),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    plin_flow_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp       (smp),
        .res       (res),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // output side: random stall bursts, one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                res.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                res.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send(input logic signed [plin_pkg::RAW_W-1:0] raw);
        smp.valid <= 1'b1;
        smp.raw_pressure <= raw;
        do
            @(posedge clk);
        while (!smp.ready);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic settle();
        smp.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic load_coefs(input logic [plin_pkg::C_W-1:0] a,
                              input logic [plin_pkg::C_W-1:0] b,
                              input logic [plin_pkg::C_W-1:0] c,
                              input logic [plin_pkg::C_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= plin_pkg::CFG_CUBIC;
        cfg_wdata <= a;
        @(posedge clk);
        cfg_index <= plin_pkg::CFG_SQUARE;
        cfg_wdata <= b;
        @(posedge clk);
        cfg_index <= plin_pkg::CFG_LINEAR;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_index <= plin_pkg::CFG_OFFSET;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [plin_pkg::RAW_W-1:0] pick_raw();
        case ($urandom_range(0, 5))
            0:       return plin_pkg::RAW_W'($urandom_range(0, 300));
            1:       return plin_pkg::RAW_W'(-$urandom_range(1, 300));
            2:       return $urandom_range(0, 1)
                            ? plin_pkg::RAW_W'(32'h7fff - $urandom_range(0, 20))
                            : plin_pkg::RAW_W'(32'h8000 + $urandom_range(0, 20));
            default: return plin_pkg::RAW_W'($urandom);
        endcase
    endfunction

    task automatic random_batch(input int n);
        repeat (n) send(pick_raw());
    endtask

    initial
    begin
        logic signed [plin_pkg::RAW_W-1:0] dir [] = '{16'sd0, 16'sd1, -16'sd1, 16'sd2,
                                                      -16'sd2, 16'sd60, -16'sd60,
                                                      16'sd255, -16'sd256, 16'sd1000,
                                                      -16'sd1000, 16'sh5555, -16'sh5556,
                                                      16'sh2aaa, 16'sd32767, -16'sd32767,
                                                      16'sh8000};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir[i])
            send(dir[i]);
        settle();

        // extremes: large positive and negative coefficients force clipping
        load_coefs(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff);
        foreach (dir[i])
            send(dir[i]);
        random_batch(150);
        settle();

        load_coefs(24'h800000, 24'h800000, 24'h800000, 24'h800000);
        random_batch(150);
        settle();

        load_coefs(24'h000000, 24'h000000, 24'h000000, 24'h000000);
        random_batch(100);
        settle();

        repeat (3)
        begin
            load_coefs(plin_pkg::C_W'($urandom), plin_pkg::C_W'($urandom),
                       plin_pkg::C_W'($urandom), plin_pkg::C_W'($urandom));
            random_batch(100);
            settle();
        end

        // long output hold-off while samples keep coming
        load_coefs(-24'sd439, 24'sd17144, 24'sd486873, -24'sd61630);
        hold_req = 1'b1;
        idle_on = 1'b0;
        random_batch(120);
        idle_on = 1'b1;
        random_batch(200);

        idle_on = 1'b0;
        random_batch(150);
        smp.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/plin_pkg.sv
hw/rtl/plin_if.sv
hw/rtl/plin_front.sv
hw/rtl/plin_sqrt_cell.sv
hw/rtl/plin_horner.sv
hw/rtl/pressure_to_flow_linearizer_core.sv
sim/plin_flow_checker.sv
sim/tb_pressure_to_flow_linearizer_core.sv
